// ----- rtl/wsd_pkg.sv -----
// Shared types, constants and helpers for the LED chain driver.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package wsd_pkg;

    // Chain length and frame buffer addressing
    localparam int LED_COUNT = 128;
    localparam int ADDR_W    = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam logic [ADDR_W-1:0] LAST_LED = ADDR_W'(LED_COUNT - 1);

    // Opcodes of an input beat
    localparam logic [1:0] OP_SET   = 2'd0;
    localparam logic [1:0] OP_FILL  = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;
    localparam logic [1:0] OP_TICK  = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_ZERO_HIGH = 3'd0;
    localparam logic [2:0] CFG_ZERO_LOW  = 3'd1;
    localparam logic [2:0] CFG_ONE_HIGH  = 3'd2;
    localparam logic [2:0] CFG_ONE_LOW   = 3'd3;
    localparam logic [2:0] CFG_LATCH     = 3'd4;

    // Configuration reset values
    localparam logic [7:0]  RST_ZERO_HIGH = 8'd8;
    localparam logic [7:0]  RST_ZERO_LOW  = 8'd17;
    localparam logic [7:0]  RST_ONE_HIGH  = 8'd16;
    localparam logic [7:0]  RST_ONE_LOW   = 8'd9;
    localparam logic [15:0] RST_LATCH     = 16'd6000;

    // Waveform phase of the serializer
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HIGH,
        PH_LOW,
        PH_LATCH
    } phase_t;

    // Item sequencer: take a beat, then execute once read data is back
    typedef enum logic {
        CTL_IDLE,
        CTL_EXEC
    } ctl_state_t;

    // Bit timing settings
    typedef struct packed {
        logic [7:0]  zero_high;
        logic [7:0]  zero_low;
        logic [7:0]  one_high;
        logic [7:0]  one_low;
        logic [15:0] latch;
    } tick_cfg_t;

    // Frame buffer access request
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [23:0]       wr_data;
    } mem_req_t;

    // A programmed count of zero behaves as one tick
    function automatic logic [15:0] at_least_one(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

    // Stored {red, green, blue} goes out on the wire as green, red, blue
    function automatic logic [23:0] wire_order(input logic [23:0] rgb);
        return {rgb[15:8], rgb[23:16], rgb[7:0]};
    endfunction

endpackage

`default_nettype wire

// ----- rtl/wsd_frame_mem.sv -----
// Frame buffer: one synchronous RAM of LED colors with a registered read.
// Per-entry valid flops make never-written entries read as zero after reset.
// Depends on wsd_pkg.
`default_nettype none

module wsd_frame_mem (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wsd_pkg::mem_req_t     req,
    output logic [23:0]           rd_data
);
    import wsd_pkg::*;

    logic [23:0]          mem [LED_COUNT];
    logic [LED_COUNT-1:0] vld_reg;
    logic [23:0]          rd_data_reg;
    logic                 rd_vld_reg;

    // Write port and registered read
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    // Mark written entries; reset returns the whole buffer to zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                vld_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_vld_reg <= vld_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : 24'd0;

endmodule

`default_nettype wire

// ----- rtl/wsd_engine.sv -----
// Command sequencer and waveform serializer: reads the frame buffer,
// updates the chain state, writes back and registers one result per beat.
// Depends on wsd_pkg; drives wsd_frame_mem through a mem_req_t.
`default_nettype none

module wsd_engine (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        opcode,
    input  wire logic [6:0]        led_index,
    input  wire logic [7:0]        red,
    input  wire logic [7:0]        green,
    input  wire logic [7:0]        blue,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   data_line,
    output logic                   busy_res,
    output logic                   dirty,
    output logic                   accepted,
    input  wsd_pkg::tick_cfg_t     cfg,
    output wsd_pkg::mem_req_t      mem_req,
    input  wire logic [23:0]       rd_data
);
    import wsd_pkg::*;

    // Sequencer and captured beat
    ctl_state_t        ctl_reg, ctl_next;
    logic [1:0]        op_reg;
    logic [6:0]        idx_reg;
    logic [23:0]       colour_reg;
    logic              take;

    // Chain state
    logic              dirty_reg, dirty_next;
    logic              fill_reg, fill_next;
    logic [ADDR_W-1:0] send_pos_reg, send_pos_next;
    logic [4:0]        bit_pos_reg, bit_pos_next;
    logic [15:0]       period_reg, period_next;
    phase_t            phase_reg, phase_next;
    logic [23:0]       shifter_reg, shifter_next;

    // Result register
    logic              out_valid_reg;
    logic              line_reg, busy_reg, dirty_out_reg, acc_reg;
    logic              line_calc, acc_calc;

    // Step helpers
    logic              busy_now;
    logic [15:0]       period_dec;
    logic [23:0]       shifted;
    logic [23:0]       loaded;

    // Take a beat only when idle and the result slot frees by the next edge
    assign take     = (ctl_reg == CTL_IDLE) && in_valid && !in_stall;
    assign in_stall = (ctl_reg != CTL_IDLE) || (out_valid_reg && out_stall);

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= CTL_IDLE;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_comb
    begin
        ctl_next = ctl_reg;
        case (ctl_reg)
            CTL_IDLE: if (take) ctl_next = CTL_EXEC;
            CTL_EXEC: ctl_next = CTL_IDLE;
            default:  ctl_next = CTL_IDLE;
        endcase
    end

    // Hold the beat's payload while its read is in flight
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op_reg     <= opcode;
            idx_reg    <= led_index;
            colour_reg <= {red, green, blue};
        end
    end

    // One step of the chain state, evaluated with the read data in hand
    always_comb
    begin
        dirty_next    = dirty_reg;
        fill_next     = fill_reg;
        send_pos_next = send_pos_reg;
        bit_pos_next  = bit_pos_reg;
        period_next   = period_reg;
        phase_next    = phase_reg;
        shifter_next  = shifter_reg;
        acc_calc      = 1'b0;
        line_calc     = 1'b0;

        // Read the LED that the step may need: first LED for a flush, else the next one
        mem_req.rd_en   = take;
        mem_req.rd_addr = (opcode == OP_FLUSH) ? '0 : send_pos_reg + ADDR_W'(1);

        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = send_pos_reg;
        mem_req.wr_data = shifter_reg;

        busy_now   = fill_reg || (phase_reg != PH_IDLE);
        period_dec = (period_reg == 16'd0) ? 16'd0 : period_reg - 16'd1;
        shifted    = {shifter_reg[22:0], 1'b0};
        loaded     = wire_order(rd_data);

        if (op_reg == OP_TICK)
        begin
            acc_calc  = 1'b1;
            line_calc = (phase_reg == PH_HIGH);
            if (fill_reg)
            begin
                // Fill walk: write one LED per tick
                mem_req.wr_en = 1'b1;
                if (send_pos_reg == LAST_LED)
                begin
                    fill_next     = 1'b0;
                    send_pos_next = '0;
                end
                else
                begin
                    send_pos_next = send_pos_reg + ADDR_W'(1);
                end
            end
            else if (phase_reg != PH_IDLE)
            begin
                period_next = period_dec;
                if (period_dec == 16'd0)
                begin
                    case (phase_reg)
                        PH_HIGH:
                        begin
                            phase_next  = PH_LOW;
                            period_next = at_least_one({8'd0, shifter_reg[23] ?
                                                        cfg.one_low : cfg.zero_low});
                        end
                        PH_LOW:
                        begin
                            if (bit_pos_reg == 5'd23)
                            begin
                                if (send_pos_reg == LAST_LED)
                                begin
                                    // Last LED done: enter latch
                                    shifter_next  = shifted;
                                    phase_next    = PH_LATCH;
                                    period_next   = at_least_one(cfg.latch);
                                    bit_pos_next  = 5'd0;
                                    send_pos_next = '0;
                                end
                                else
                                begin
                                    // Load the next LED from the read data
                                    send_pos_next = send_pos_reg + ADDR_W'(1);
                                    shifter_next  = loaded;
                                    bit_pos_next  = 5'd0;
                                    phase_next    = PH_HIGH;
                                    period_next   = at_least_one({8'd0, loaded[23] ?
                                                                  cfg.one_high : cfg.zero_high});
                                end
                            end
                            else
                            begin
                                shifter_next = shifted;
                                bit_pos_next = bit_pos_reg + 5'd1;
                                phase_next   = PH_HIGH;
                                period_next  = at_least_one({8'd0, shifted[23] ?
                                                            cfg.one_high : cfg.zero_high});
                            end
                        end
                        default:
                        begin
                            // Latch over: frame complete
                            phase_next    = PH_IDLE;
                            period_next   = 16'd0;
                            send_pos_next = '0;
                            dirty_next    = 1'b0;
                        end
                    endcase
                end
            end
        end
        else
        begin
            if (!busy_now)
            begin
                case (op_reg)
                    OP_SET:
                    begin
                        if (int'(idx_reg) < LED_COUNT)
                        begin
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = ADDR_W'(idx_reg);
                            mem_req.wr_data = colour_reg;
                            dirty_next      = 1'b1;
                            acc_calc        = 1'b1;
                        end
                    end
                    OP_FILL:
                    begin
                        fill_next     = 1'b1;
                        send_pos_next = '0;
                        shifter_next  = colour_reg;
                        dirty_next    = 1'b1;
                        acc_calc      = 1'b1;
                    end
                    default:
                    begin
                        // Flush: start the frame only when something changed
                        if (dirty_reg)
                        begin
                            send_pos_next = '0;
                            shifter_next  = loaded;
                            bit_pos_next  = 5'd0;
                            phase_next    = PH_HIGH;
                            period_next   = at_least_one({8'd0, loaded[23] ?
                                                          cfg.one_high : cfg.zero_high});
                            acc_calc      = 1'b1;
                        end
                    end
                endcase
            end
            line_calc = (phase_next == PH_HIGH);
        end

        // Only the execute cycle commits a write
        if (ctl_reg != CTL_EXEC)
        begin
            mem_req.wr_en = 1'b0;
        end
    end

    // Commit chain state on the execute cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dirty_reg    <= 1'b0;
            fill_reg     <= 1'b0;
            send_pos_reg <= '0;
            bit_pos_reg  <= 5'd0;
            period_reg   <= 16'd0;
            phase_reg    <= PH_IDLE;
            shifter_reg  <= 24'd0;
        end
        else if (ctl_reg == CTL_EXEC)
        begin
            dirty_reg    <= dirty_next;
            fill_reg     <= fill_next;
            send_pos_reg <= send_pos_next;
            bit_pos_reg  <= bit_pos_next;
            period_reg   <= period_next;
            phase_reg    <= phase_next;
            shifter_reg  <= shifter_next;
        end
    end

    // Result beat: load on execute, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl_reg == CTL_EXEC)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl_reg == CTL_EXEC)
        begin
            line_reg      <= line_calc;
            busy_reg      <= fill_next || (phase_next != PH_IDLE);
            dirty_out_reg <= dirty_next;
            acc_reg       <= acc_calc;
        end
    end

    assign out_valid = out_valid_reg;
    assign data_line = line_reg;
    assign busy_res  = busy_reg;
    assign dirty     = dirty_out_reg;
    assign accepted  = acc_reg;

endmodule

`default_nettype wire

// ----- rtl/ws2812_led_chain_driver_top.sv -----
// LED chain driver top: bit timing registers, sequencer and frame buffer RAM.
// Result: a taken beat executes in the next state, which registers its result.
// Beats: a new beat is taken only once the last has executed, after its buffer read.
// Reset: asynchronous, active low; buffer reads as all zero, dirty clear,
// serializer idle, timing registers at their default values.
`default_nettype none

module ws2812_led_chain_driver_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  opcode,
    input  wire logic [6:0]  led_index,
    input  wire logic [7:0]  red,
    input  wire logic [7:0]  green,
    input  wire logic [7:0]  blue,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             data_line,
    output logic             busy_res,
    output logic             dirty,
    output logic             accepted,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import wsd_pkg::*;

    tick_cfg_t cfg_reg;
    mem_req_t  mem_req;
    logic [23:0] rd_data;

    assign cfg_ready = 1'b1;

    // Timing register writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.zero_high <= RST_ZERO_HIGH;
            cfg_reg.zero_low  <= RST_ZERO_LOW;
            cfg_reg.one_high  <= RST_ONE_HIGH;
            cfg_reg.one_low   <= RST_ONE_LOW;
            cfg_reg.latch     <= RST_LATCH;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ZERO_HIGH: cfg_reg.zero_high <= cfg_data[7:0];
                CFG_ZERO_LOW:  cfg_reg.zero_low  <= cfg_data[7:0];
                CFG_ONE_HIGH:  cfg_reg.one_high  <= cfg_data[7:0];
                CFG_ONE_LOW:   cfg_reg.one_low   <= cfg_data[7:0];
                CFG_LATCH:     cfg_reg.latch     <= cfg_data;
                default:       ;
            endcase
        end
    end

    wsd_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .led_index (led_index),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .data_line (data_line),
        .busy_res  (busy_res),
        .dirty     (dirty),
        .accepted  (accepted),
        .cfg       (cfg_reg),
        .mem_req   (mem_req),
        .rd_data   (rd_data)
    );

    wsd_frame_mem u_frame_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .rd_data (rd_data)
    );

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// Self-checking bench for the LED chain driver: random and directed command beats,
// an in-bench predictor of the frame buffer and serializer, and per-field result checks.
// Depends on rtl/wsd_pkg.sv and rtl/ws2812_led_chain_driver_top.sv.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wsd_pkg::*;

    localparam int unsigned BITS_PER_LED   = 24;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned PRESSURE_AT    = 300;
    localparam int unsigned PRESSURE_LEN   = 400;
    localparam int unsigned NOISE_WINDOW   = 3000;
    // Unmapped register index: a write there has no effect
    localparam logic [2:0]  CFG_SPARE      = 3'd7;

    typedef struct packed {
        logic [1:0] opcode;
        logic [6:0] led_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } cmd_t;

    typedef struct packed {
        logic data_line;
        logic busy;
        logic dirty;
        logic accepted;
    } chain_status_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b1;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  opcode = OP_TICK;
    logic [6:0]  led_index = '0;
    logic [7:0]  red = '0;
    logic [7:0]  green = '0;
    logic [7:0]  blue = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        data_line;
    logic        busy_res;
    logic        dirty;
    logic        accepted;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = CFG_ZERO_HIGH;
    logic [15:0] cfg_data = '0;

    ws2812_led_chain_driver_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .led_index (led_index),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .data_line (data_line),
        .busy_res  (busy_res),
        .dirty     (dirty),
        .accepted  (accepted),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Predicted chain state
    logic [23:0]  frame_mem [LED_COUNT];
    tick_cfg_t    timing;
    phase_t       ser_phase;
    logic [15:0]  ser_count;
    int unsigned  ser_led;
    int unsigned  ser_bit;
    logic [23:0]  ser_bits;
    logic         fill_busy;
    logic         buf_dirty;

    // Bench bookkeeping
    cmd_t          pending_cmds [$];
    chain_status_t expected_status [$];
    int unsigned   cmds_queued = 0;
    int unsigned   status_seen = 0;
    int unsigned   fault_count = 0;
    int unsigned   idle_cycles = 0;
    logic          beat_taken = 1'b0;
    cmd_t          tx_cmd;
    int unsigned   tx_gap_left = 0;
    int unsigned   tx_calm = 0;
    int unsigned   rx_hold_left = 0;
    int unsigned   rx_calm = 0;
    logic          pressure_done = 1'b0;

    function automatic logic [15:0] ticks_or_one(input logic [15:0] count);
        return (count == 16'd0) ? 16'd1 : count;
    endfunction

    function automatic void reset_predictor();
        for (int i = 0; i < LED_COUNT; i++)
        begin
            frame_mem[i] = '0;
        end
        timing    = {RST_ZERO_HIGH, RST_ZERO_LOW, RST_ONE_HIGH, RST_ONE_LOW, RST_LATCH};
        ser_phase = PH_IDLE;
        ser_count = '0;
        ser_led   = 0;
        ser_bit   = 0;
        ser_bits  = '0;
        fill_busy = 1'b0;
        buf_dirty = 1'b0;
    endfunction

    function automatic void start_high();
        ser_phase = PH_HIGH;
        ser_count = ticks_or_one(ser_bits[23] ? timing.one_high : timing.zero_high);
    endfunction

    // Load the next LED in wire order: green, red, blue
    function automatic void load_led();
        logic [23:0] rgb;
        rgb = (ser_led < LED_COUNT) ? frame_mem[ser_led] : 24'd0;
        ser_bits = {rgb[15:8], rgb[23:16], rgb[7:0]};
        ser_bit = 0;
        start_high();
    endfunction

    function automatic void end_period();
        case (ser_phase)
            PH_HIGH:
            begin
                ser_phase = PH_LOW;
                ser_count = ticks_or_one(ser_bits[23] ? timing.one_low : timing.zero_low);
            end
            PH_LOW:
            begin
                ser_bits = ser_bits << 1;
                ser_bit++;
                if (ser_bit >= BITS_PER_LED)
                begin
                    ser_led++;
                    if (ser_led >= LED_COUNT)
                    begin
                        ser_phase = PH_LATCH;
                        ser_count = ticks_or_one(timing.latch);
                        ser_bit = 0;
                    end
                    else
                    begin
                        load_led();
                    end
                end
                else
                begin
                    start_high();
                end
            end
            default:
            begin
                // latch over: frame done, buffer counts as clean
                ser_phase = PH_IDLE;
                ser_count = '0;
                ser_led = 0;
                buf_dirty = 1'b0;
            end
        endcase
    endfunction

    // One tick: a fill walk writes one LED, otherwise the waveform advances
    function automatic void advance_tick();
        if (fill_busy)
        begin
            if (ser_led < LED_COUNT)
                frame_mem[ser_led] = ser_bits;
            ser_led++;
            if (ser_led >= LED_COUNT)
            begin
                fill_busy = 1'b0;
                ser_led = 0;
            end
        end
        else if (ser_phase != PH_IDLE)
        begin
            if (ser_count > 0)
                ser_count--;
            if (ser_count == 0)
                end_period();
        end
    endfunction

    function automatic chain_status_t apply_command(input cmd_t c);
        chain_status_t r;
        logic          was_busy;
        logic          took;
        was_busy = fill_busy || (ser_phase != PH_IDLE);
        took = 1'b0;
        if (c.opcode == OP_TICK)
        begin
            // level driven during this tick, taken before it is counted
            r.data_line = (ser_phase == PH_HIGH);
            advance_tick();
            took = 1'b1;
        end
        else
        begin
            if (!was_busy)
            begin
                case (c.opcode)
                    OP_SET:
                    begin
                        if (c.led_index < LED_COUNT)
                        begin
                            frame_mem[c.led_index] = {c.red, c.green, c.blue};
                            buf_dirty = 1'b1;
                            took = 1'b1;
                        end
                    end
                    OP_FILL:
                    begin
                        fill_busy = 1'b1;
                        ser_led = 0;
                        ser_bits = {c.red, c.green, c.blue};
                        buf_dirty = 1'b1;
                        took = 1'b1;
                    end
                    default:
                    begin
                        // flush of a clean buffer sends nothing
                        if (buf_dirty)
                        begin
                            ser_led = 0;
                            load_led();
                            took = 1'b1;
                        end
                    end
                endcase
            end
            r.data_line = (ser_phase == PH_HIGH);
        end
        r.busy = fill_busy || (ser_phase != PH_IDLE);
        r.dirty = buf_dirty;
        r.accepted = took;
        return r;
    endfunction

    // Mostly no gap, some short ones, a few long, and now and then a calm run
    function automatic int unsigned pick_gap(inout int unsigned calm);
        int unsigned roll;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        roll = $urandom_range(0, 199);
        if (roll == 0)
        begin
            calm = $urandom_range(40, 120);
            return 0;
        end
        if (roll < 110)
            return 0;
        if (roll < 180)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] rand_level();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic cmd_t make_cmd(input logic [1:0] op);
        cmd_t c;
        c.opcode = op;
        c.led_index = 7'($urandom_range(0, 127));
        c.red = rand_level();
        c.green = rand_level();
        c.blue = rand_level();
        return c;
    endfunction

    function automatic void queue_cmd(input cmd_t c);
        pending_cmds.push_back(c);
        cmds_queued++;
    endfunction

    // Fill, then the walk ticks with refused commands mixed into its first part
    function automatic void queue_fill_walk();
        int unsigned walk;
        queue_cmd(make_cmd(OP_FILL));
        walk = LED_COUNT + $urandom_range(0, 4);
        for (int unsigned t = 0; t < walk; t++)
        begin
            if (t < LED_COUNT - 8 && $urandom_range(0, 7) == 0)
                queue_cmd(make_cmd(2'($urandom_range(OP_SET, OP_FLUSH))));
            queue_cmd(make_cmd(OP_TICK));
        end
    endfunction

    // Dirty the buffer, flush, and tick the frame along
    function automatic void queue_frame(input int unsigned ticks, input int unsigned noisy);
        repeat ($urandom_range(1, 4))
            queue_cmd(make_cmd(OP_SET));
        queue_cmd(make_cmd(OP_FLUSH));
        queue_cmd(make_cmd(OP_FLUSH));
        for (int unsigned t = 0; t < ticks; t++)
        begin
            if (t < noisy && $urandom_range(0, 9) == 0)
                queue_cmd(make_cmd(2'($urandom_range(OP_SET, OP_FLUSH))));
            queue_cmd(make_cmd(OP_TICK));
        end
        queue_cmd(make_cmd(OP_FLUSH));
    endfunction

    // Sets, fill walks and loose ticks; any flush falls in a fill walk and is refused, so no frame starts
    function automatic void queue_mix(input int unsigned count);
        int unsigned start;
        int unsigned roll;
        start = cmds_queued;
        while (cmds_queued - start < count)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 35)
            begin
                repeat ($urandom_range(1, 6))
                    queue_cmd(make_cmd(OP_SET));
            end
            else if (roll < 55)
            begin
                queue_fill_walk();
            end
            else
            begin
                repeat ($urandom_range(1, 20))
                    queue_cmd(make_cmd(($urandom_range(0, 9) < 7) ? OP_TICK : OP_SET));
            end
        end
    endfunction

    // Called at a falling edge; returns at a falling edge with the write still offered
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_ZERO_HIGH: timing.zero_high = value[7:0];
            CFG_ZERO_LOW:  timing.zero_low = value[7:0];
            CFG_ONE_HIGH:  timing.one_high = value[7:0];
            CFG_ONE_LOW:   timing.one_low = value[7:0];
            CFG_LATCH:     timing.latch = value;
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (status_seen < cmds_queued)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    function automatic void check_bit(input string field, input logic want, input logic got);
        if (got !== want)
        begin
            $error("%s: expected %0b, got %0b", field, want, got);
            fault_count++;
        end
    endfunction

    // Driver: present a beat, hold it while stalled, then optionally idle
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || beat_taken))
        begin
            if (tx_gap_left > 0)
            begin
                tx_gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_cmds.size() != 0)
            begin
                tx_cmd = pending_cmds.pop_front();
                opcode <= tx_cmd.opcode;
                led_index <= tx_cmd.led_index;
                red <= tx_cmd.red;
                green <= tx_cmd.green;
                blue <= tx_cmd.blue;
                in_valid <= 1'b1;
                tx_gap_left = pick_gap(tx_calm);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off to back the block up
    always @(negedge clk)
    begin
        if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            out_stall <= 1'b1;
        end
        else if (!pressure_done && status_seen >= PRESSURE_AT)
        begin
            pressure_done = 1'b1;
            rx_hold_left = PRESSURE_LEN - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            rx_hold_left = ($urandom_range(0, 3) == 0) ? pick_gap(rx_calm) : 0;
            out_stall <= (rx_hold_left > 0);
            if (rx_hold_left > 0)
                rx_hold_left--;
        end
    end

    // Monitor: predict each accepted command beat, check each result beat
    always @(posedge clk)
    begin
        chain_status_t want;
        beat_taken = 1'b0;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                expected_status.push_back(apply_command({opcode, led_index, red, green, blue}));
                beat_taken = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                status_seen++;
                if (expected_status.size() == 0)
                begin
                    $error("result beat with no command waiting for it");
                    fault_count++;
                end
                else
                begin
                    want = expected_status.pop_front();
                    check_bit("data_line", want.data_line, data_line);
                    check_bit("busy_res", want.busy, busy_res);
                    check_bit("dirty", want.dirty, dirty);
                    check_bit("accepted", want.accepted, accepted);
                end
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        reset_predictor();
        repeat (5)
            @(negedge clk);
        rst_n <= 1'b1;

        // Directed: idle tick, clean flush, colour extremes, refusals during a fill
        queue_cmd(make_cmd(OP_TICK));
        queue_cmd(make_cmd(OP_FLUSH));
        queue_cmd({OP_SET, 7'd0, 8'h00, 8'h00, 8'h00});
        queue_cmd({OP_SET, 7'd127, 8'hFF, 8'hFF, 8'hFF});
        queue_cmd({OP_SET, 7'h55, 8'hA5, 8'h5A, 8'h0F});
        queue_cmd({OP_SET, 7'h2A, 8'h5A, 8'hA5, 8'hF0});
        queue_cmd(make_cmd(OP_TICK));
        queue_cmd({OP_FILL, 7'd0, 8'hFF, 8'h00, 8'hFF});
        queue_cmd(make_cmd(OP_TICK));
        queue_cmd(make_cmd(OP_TICK));
        queue_cmd({OP_SET, 7'd3, 8'h12, 8'h34, 8'h56});
        queue_cmd(make_cmd(OP_FILL));
        queue_cmd(make_cmd(OP_FLUSH));
        // finish the walk
        repeat (LED_COUNT)
            queue_cmd(make_cmd(OP_TICK));
        queue_mix(300);
        wait_drained();

        // Shortest bit timing: the first LEDs of a frame go out
        write_reg(CFG_ZERO_HIGH, {8'($urandom_range(0, 255)), 8'd1});
        write_reg(CFG_ZERO_LOW, {8'($urandom_range(0, 255)), 8'd1});
        write_reg(CFG_ONE_HIGH, {8'($urandom_range(0, 255)), 8'd1});
        write_reg(CFG_ONE_LOW, {8'($urandom_range(0, 255)), 8'd1});
        write_reg(CFG_LATCH, 16'd1);
        write_reg(CFG_SPARE, 16'hFFFF);
        cfg_valid <= 1'b0;
        queue_frame(250, NOISE_WINDOW);
        queue_mix(150);
        wait_drained();

        // Longest timing: the running frame barely moves
        write_reg(CFG_ZERO_HIGH, 16'hFFFF);
        write_reg(CFG_ZERO_LOW, 16'h00FF);
        write_reg(CFG_ONE_HIGH, 16'h00FF);
        write_reg(CFG_ONE_LOW, 16'hFFFF);
        write_reg(CFG_LATCH, 16'hFFFF);
        cfg_valid <= 1'b0;
        queue_frame(120, 120);
        wait_drained();

        // Zero counts act as one; the frame still running keeps going
        write_reg(CFG_ZERO_HIGH, 16'd0);
        write_reg(CFG_ZERO_LOW, 16'd1);
        write_reg(CFG_ONE_HIGH, 16'd2);
        write_reg(CFG_ONE_LOW, 16'd0);
        write_reg(CFG_LATCH, 16'd0);
        cfg_valid <= 1'b0;
        queue_frame(150, NOISE_WINDOW);
        queue_mix(150);
        queue_cmd(make_cmd(OP_FLUSH));
        repeat (50)
            queue_cmd(make_cmd(OP_TICK));
        wait_drained();

        if (fault_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/wsd_pkg.sv
rtl/wsd_frame_mem.sv
rtl/wsd_engine.sv
rtl/ws2812_led_chain_driver_top.sv
test/tb.sv
